>>> rtl/core/lfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LLF face dissipation package
// Shared constants, pipeline step state types and the divide and square root
// step functions.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STEPS       = 64;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
  localparam int SQRT_STEPS      = 32;
  localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;
  localparam int MID_STAGES      = DIV_STAGES + SQRT_STAGES;
  localparam int LATENCY         = MID_STAGES + 6;

  localparam int ADDR_W  = 3;
  localparam int GAMMA_W = 18;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET   = 18'd91750;
  localparam logic [0:0]         REG_GAMMA_IDX = 1'b0;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] nq;
  } div_st_t;

  typedef struct packed {
    logic [31:0] root;
    logic [33:0] rem;
  } sqrt_st_t;

  function automatic logic [31:0] div_step(input logic [30:0] rem, input logic nbit,
                                           input logic [30:0] den);
    logic [31:0] trial;
    logic [31:0] diffv;
    trial = {rem, nbit};
    diffv = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, diffv[30:0]};
    end else begin
      div_step = {1'b0, trial[30:0]};
    end
  endfunction

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [1:0] pair);
    sqrt_st_t    res;
    logic [35:0] acc;
    logic [35:0] trial;
    logic [35:0] diffv;
    acc   = {st.rem, pair};
    trial = {2'b00, st.root, 2'b01};
    diffv = acc - trial;
    if (acc >= trial) begin
      res.rem  = diffv[33:0];
      res.root = {st.root[30:0], 1'b1};
    end else begin
      res.rem  = acc[33:0];
      res.root = {st.root[30:0], 1'b0};
    end
    sqrt_step = res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/llf_face_dissipation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LLF face dissipation unit
// Rusanov dissipation term and largest wave speed times area for one face
// and one conserved component, Q16.16 fixed point.
//
//   channel | ports                      | handshake
//   --------+----------------------------+---------------------------------
//   input   | in_*                       | start && !busy
//   result  | out_*                      | out_valid, one cycle, no stall
//   config  | psel penable pwrite paddr  | APB write, pready tied high
//
// One transaction enters every cycle; busy never rises.
// 54 register stages: 2 input, 32 divider, 16 square root and 4 output.
// Synchronous active-low reset clears the valids and reloads gamma_ratio.
// ----------------------------------------------------------------------------
module llf_face_dissipation_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_face_x,
  input  logic signed [31:0]         in_face_y,
  input  logic        [30:0]         in_left_density,
  input  logic signed [31:0]         in_left_u,
  input  logic signed [31:0]         in_left_v,
  input  logic        [30:0]         in_left_pressure,
  input  logic        [30:0]         in_right_density,
  input  logic signed [31:0]         in_right_u,
  input  logic signed [31:0]         in_right_v,
  input  logic        [30:0]         in_right_pressure,
  input  logic signed [31:0]         in_var_difference,
  input  logic        [1:0]          in_component,
  output logic                       out_valid,
  output logic signed [31:0]         out_flux_term,
  output logic        [30:0]         out_wave_speed_area,
  output logic        [1:0]          out_component_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lfd_pkg::*;

  logic               accept;
  logic               cfg_wr;
  logic [0:0]         reg_idx;
  logic [GAMMA_W-1:0] gamma_r;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == REG_GAMMA_IDX) ? {{(32-GAMMA_W){1'b0}}, gamma_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_wr && reg_idx == REG_GAMMA_IDX) begin
      gamma_r <= pwdata[GAMMA_W-1:0];
    end
  end

  // stage 1: products
  logic               s1_vld_r;
  logic signed [63:0] s1_fxx_r, s1_fyy_r;
  logic signed [63:0] s1_ulfx_r, s1_vlfy_r, s1_urfx_r, s1_vrfy_r;
  logic [48:0]        s1_gpl_r, s1_gpr_r;
  logic [30:0]        s1_rhol_r, s1_rhor_r;
  logic [31:0]        s1_diff_r;
  logic [1:0]         s1_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_fxx_r  <= in_face_x * in_face_x;
    s1_fyy_r  <= in_face_y * in_face_y;
    s1_ulfx_r <= in_left_u * in_face_x;
    s1_vlfy_r <= in_left_v * in_face_y;
    s1_urfx_r <= in_right_u * in_face_x;
    s1_vrfy_r <= in_right_v * in_face_y;
    s1_gpl_r  <= gamma_r * in_left_pressure;
    s1_gpr_r  <= gamma_r * in_right_pressure;
    s1_rhol_r <= (in_left_density == 31'h0) ? 31'h1 : in_left_density;
    s1_rhor_r <= (in_right_density == 31'h0) ? 31'h1 : in_right_density;
    s1_diff_r <= in_var_difference;
    s1_comp_r <= in_component;
  end

  // stage 2: radicand, normal speed magnitudes, divide setup
  logic signed [64:0] sl, sr;
  logic [64:0]        magl, magr;
  logic               s2_vld_r;
  logic [63:0]        s2_rad_r;
  logic [47:0]        s2_magl_r, s2_magr_r;
  logic [48:0]        s2_gpl_r, s2_gpr_r;
  logic [30:0]        s2_rhol_r, s2_rhor_r;
  logic               s2_satl_r, s2_satr_r;
  logic [31:0]        s2_diff_r;
  logic [1:0]         s2_comp_r;

  always_comb begin
    sl   = 65'(s1_ulfx_r) + 65'(s1_vlfy_r);
    sr   = 65'(s1_urfx_r) + 65'(s1_vrfy_r);
    magl = sl[64] ? -sl : sl;
    magr = sr[64] ? -sr : sr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_rad_r  <= $unsigned(s1_fxx_r + s1_fyy_r);
    s2_magl_r <= magl[63:16];
    s2_magr_r <= magr[63:16];
    s2_gpl_r  <= s1_gpl_r;
    s2_gpr_r  <= s1_gpr_r;
    s2_rhol_r <= s1_rhol_r;
    s2_rhor_r <= s1_rhor_r;
    s2_satl_r <= s1_gpl_r[48] && (s1_rhol_r == 31'h1);
    s2_satr_r <= s1_gpr_r[48] && (s1_rhor_r == 31'h1);
    s2_diff_r <= s1_diff_r;
    s2_comp_r <= s1_comp_r;
  end

  // divide, square roots and alignment
  logic [63:0]  quot_l, quot_r;
  logic [1:0]   sat_d;
  logic [63:0]  a2_l, a2_r;
  logic [31:0]  a_l, a_r;
  logic [31:0]  ds_raw, ds_d;
  logic [129:0] side_d;
  logic [MID_STAGES-1:0] vld_r;

  lfd_div_pipe u_div_l (
    .clk      (clk),
    .dividend ({s2_gpl_r[47:0], 16'h0}),
    .rem_init ({30'h0, s2_gpl_r[48]}),
    .divisor  (s2_rhol_r),
    .quotient (quot_l)
  );

  lfd_div_pipe u_div_r (
    .clk      (clk),
    .dividend ({s2_gpr_r[47:0], 16'h0}),
    .rem_init ({30'h0, s2_gpr_r[48]}),
    .divisor  (s2_rhor_r),
    .quotient (quot_r)
  );

  lfd_delay #(.WIDTH(2), .DEPTH(DIV_STAGES)) u_sat_dly (
    .clk  (clk),
    .din  ({s2_satl_r, s2_satr_r}),
    .dout (sat_d)
  );

  assign a2_l = sat_d[1] ? {64{1'b1}} : quot_l;
  assign a2_r = sat_d[0] ? {64{1'b1}} : quot_r;

  lfd_sqrt_pipe u_sqrt_al (.clk(clk), .radicand(a2_l), .root(a_l));
  lfd_sqrt_pipe u_sqrt_ar (.clk(clk), .radicand(a2_r), .root(a_r));
  lfd_sqrt_pipe u_sqrt_ds (.clk(clk), .radicand(s2_rad_r), .root(ds_raw));

  lfd_delay #(.WIDTH(32), .DEPTH(DIV_STAGES)) u_ds_dly (
    .clk  (clk),
    .din  (ds_raw),
    .dout (ds_d)
  );

  lfd_delay #(.WIDTH(130), .DEPTH(MID_STAGES)) u_side_dly (
    .clk  (clk),
    .din  ({s2_magl_r, s2_magr_r, s2_diff_r, s2_comp_r}),
    .dout (side_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MID_STAGES-2:0], s2_vld_r};
    end
  end

  // stage 3: sound speed times area
  logic        s3_vld_r;
  logic [63:0] s3_prodl_r, s3_prodr_r;
  logic [47:0] s3_magl_r, s3_magr_r;
  logic [31:0] s3_diff_r;
  logic [1:0]  s3_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= vld_r[MID_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    s3_prodl_r <= a_l * ds_d;
    s3_prodr_r <= a_r * ds_d;
    s3_magl_r  <= side_d[129:82];
    s3_magr_r  <= side_d[81:34];
    s3_diff_r  <= side_d[33:2];
    s3_comp_r  <= side_d[1:0];
  end

  // stage 4: side speeds and maximum
  logic [48:0] side_l, side_r, w_nxt;
  logic [31:0] dmag_nxt;
  logic        s4_vld_r;
  logic [48:0] s4_w_r;
  logic [31:0] s4_dmag_r;
  logic        s4_neg_r;
  logic [1:0]  s4_comp_r;

  always_comb begin
    side_l   = {1'b0, s3_magl_r} + {1'b0, s3_prodl_r[63:16]};
    side_r   = {1'b0, s3_magr_r} + {1'b0, s3_prodr_r[63:16]};
    w_nxt    = (side_l > side_r) ? side_l : side_r;
    dmag_nxt = s3_diff_r[31] ? (32'h0 - s3_diff_r) : s3_diff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_w_r    <= w_nxt;
    s4_dmag_r <= dmag_nxt;
    s4_neg_r  <= s3_diff_r[31];
    s4_comp_r <= s3_comp_r;
  end

  // stage 5: partial products of the flux magnitude
  logic        s5_vld_r;
  logic [48:0] s5_pphi_r;
  logic [63:0] s5_pplo_r;
  logic [30:0] s5_wsa_r;
  logic        s5_neg_r;
  logic [1:0]  s5_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_pphi_r <= s4_w_r[48:32] * s4_dmag_r;
    s5_pplo_r <= s4_w_r[31:0] * s4_dmag_r;
    s5_wsa_r  <= (s4_w_r > 49'h7FFFFFFF) ? 31'h7FFFFFFF : s4_w_r[30:0];
    s5_neg_r  <= s4_neg_r;
    s5_comp_r <= s4_comp_r;
  end

  // stage 6: combine, sign and saturate
  logic [64:0] fmag;
  logic [31:0] flux_nxt;

  always_comb begin
    fmag = {1'b0, s5_pphi_r, 15'h0} + {18'h0, s5_pplo_r[63:17]};
    if (s5_neg_r) begin
      flux_nxt = (fmag > 65'h80000000) ? 32'h80000000 : (32'h0 - fmag[31:0]);
    end else begin
      flux_nxt = (fmag > 65'h7FFFFFFF) ? 32'h7FFFFFFF : fmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_flux_term       <= flux_nxt;
    out_wave_speed_area <= s5_wsa_r;
    out_component_out   <= s5_comp_r;
  end

`ifndef SYNTHESIS
  a_result_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start & ~busy, LATENCY))
    else $error("result without matching accepted transaction");

  a_zero_speed_zero_flux : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wave_speed_area == 31'h0) |-> (out_flux_term == 32'sh0))
    else $error("nonzero flux with zero wave speed");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lfd_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LLF delay line
// Fixed-depth register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lfd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];
endmodule
`default_nettype wire

>>> rtl/core/lfd_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LLF pipelined divider
// Restoring divide of a 64-bit dividend by a 31-bit divisor, two quotient
// bits per stage.
// ----------------------------------------------------------------------------
module lfd_div_pipe (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [30:0] rem_init,
  input  logic [30:0] divisor,
  output logic [63:0] quotient
);
  import lfd_pkg::*;

  div_st_t     st_r  [DIV_STAGES];
  logic [30:0] den_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    div_st_t     st_in;
    div_st_t     st_nxt;
    logic [30:0] den_in;

    if (g == 0) begin : g_first
      assign st_in  = '{rem: rem_init, nq: dividend};
      assign den_in = divisor;
    end else begin : g_next
      assign st_in  = st_r[g-1];
      assign den_in = den_r[g-1];
    end

    always_comb begin
      logic [31:0] s;
      st_nxt = st_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        s          = div_step(st_nxt.rem, st_nxt.nq[63], den_in);
        st_nxt.rem = s[30:0];
        st_nxt.nq  = {st_nxt.nq[62:0], s[31]};
      end
    end

    always_ff @(posedge clk) begin
      st_r[g]  <= st_nxt;
      den_r[g] <= den_in;
    end
  end

  assign quotient = st_r[DIV_STAGES-1].nq;
endmodule
`default_nettype wire

>>> rtl/core/lfd_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LLF pipelined square root
// Digit-by-digit integer square root of a 64-bit radicand, two root bits
// per stage.
// ----------------------------------------------------------------------------
module lfd_sqrt_pipe (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import lfd_pkg::*;

  sqrt_st_t    st_r  [SQRT_STAGES];
  logic [63:0] rad_r [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    sqrt_st_t    st_in;
    sqrt_st_t    st_nxt;
    logic [63:0] rad_in;
    logic [63:0] rad_nxt;

    if (g == 0) begin : g_first
      assign st_in  = '{root: 32'h0, rem: 34'h0};
      assign rad_in = radicand;
    end else begin : g_next
      assign st_in  = st_r[g-1];
      assign rad_in = rad_r[g-1];
    end

    always_comb begin
      st_nxt  = st_in;
      rad_nxt = rad_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        st_nxt  = sqrt_step(st_nxt, rad_nxt[63:62]);
        rad_nxt = {rad_nxt[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      st_r[g]  <= st_nxt;
      rad_r[g] <= rad_nxt;
    end
  end

  assign root = st_r[SQRT_STAGES-1].root;
endmodule
`default_nettype wire

>>> tb/llf_face_dissipation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LLF face dissipation unit testbench
// Drives face transactions through the command port with random gaps and
// computes each expected dissipation term and wave speed area in an exact
// fixed point predictor. Results are checked in order, field by field.
// The ratio of specific heats is reprogrammed between phases, only while
// the pipeline is drained.
// ----------------------------------------------------------------------------
module llf_face_dissipation_unit_tb;
  import lfd_pkg::*;

  localparam int LIMIT = 4000;

  typedef struct {
    logic signed [31:0] fx, fy, lu, lv, ru, rv, diff;
    logic [30:0]        lrho, lp, rrho, rp;
    logic [1:0]         comp;
  } face_t;

  typedef struct {
    logic signed [31:0] flux;
    logic [30:0]        wsa;
    logic [1:0]         comp;
  } dissip_t;

  function automatic bit [63:0] root64(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  class dissip_board;
    bit [17:0] gamma;
    dissip_t   pending[$];
    int        checked;

    function bit [63:0] sound_speed(bit [63:0] p, bit [63:0] rho);
      bit [63:0] gp, q, r, a2;
      gp = gamma * p;
      if (rho == 0) rho = 1;
      q = gp / rho;
      r = gp % rho;
      if (q >= (64'd1 << 48)) a2 = '1;
      else a2 = (q << 16) + ((r << 16) / rho);
      return root64(a2);
    endfunction

    function bit [63:0] side_area(longint fx, longint fy, logic signed [31:0] u,
                                  logic signed [31:0] v, bit [63:0] p,
                                  bit [63:0] rho, bit [63:0] ds);
      bit [63:0] s, mag, a;
      s = longint'(u) * fx + longint'(v) * fy;
      mag = s[63] ? (64'd0 - s) : s;
      a = sound_speed(p, rho);
      return (mag >> 16) + ((a * ds) >> 16);
    endfunction

    function void note(face_t f);
      longint    fx, fy, d;
      bit [63:0] ds, wl, wr, w, dmag, hi, lo, mag;
      dissip_t   e;
      fx = f.fx;
      fy = f.fy;
      d = f.diff;
      ds = root64(fx * fx + fy * fy);
      wl = side_area(fx, fy, f.lu, f.lv, f.lp, f.lrho, ds);
      wr = side_area(fx, fy, f.ru, f.rv, f.rp, f.rrho, ds);
      w = wl > wr ? wl : wr;
      dmag = d < 0 ? -d : d;
      hi = (w >> 32) * dmag;
      lo = (w & 64'hFFFF_FFFF) * dmag;
      if (hi >= (64'd1 << 16)) mag = 64'd1 << 32;
      else mag = (hi << 15) + (lo >> 17);
      if (d < 0) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        e.flux = 32'(64'd0 - mag);
      end else begin
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        e.flux = 32'(mag);
      end
      e.wsa = w > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : 31'(w);
      e.comp = f.comp;
      pending.push_back(e);
    endfunction

    function string check(dissip_t got);
      dissip_t e;
      string   msg;
      checked++;
      if (pending.size() == 0) return "result with no transaction outstanding";
      e = pending.pop_front();
      msg = "";
      if (got.flux !== e.flux)
        msg = {msg, $sformatf(" flux %0d exp %0d", got.flux, e.flux)};
      if (got.wsa !== e.wsa)
        msg = {msg, $sformatf(" wsa %0d exp %0d", got.wsa, e.wsa)};
      if (got.comp !== e.comp)
        msg = {msg, $sformatf(" comp %0d exp %0d", got.comp, e.comp)};
      return msg;
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic signed [31:0] in_face_x, in_face_y, in_left_u, in_left_v;
  logic signed [31:0] in_right_u, in_right_v, in_var_difference;
  logic [30:0] in_left_density, in_left_pressure, in_right_density, in_right_pressure;
  logic [1:0]  in_component;
  logic        out_valid;
  logic signed [31:0] out_flux_term;
  logic [30:0] out_wave_speed_area;
  logic [1:0]  out_component_out;
  logic        psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  dissip_board board;
  int errors, sent, idle_cycles, writes;

  llf_face_dissipation_unit dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(string what);
    errors++;
    $display("[%0t] mismatch:%s", $realtime, what);
  endtask

  always @(posedge clk) begin
    dissip_t got;
    string   msg;
    if (rst_n && out_valid) begin
      got.flux = out_flux_term;
      got.wsa = out_wave_speed_area;
      got.comp = out_component_out;
      msg = board.check(got);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drive_face(face_t f);
    in_face_x <= f.fx;
    in_face_y <= f.fy;
    in_left_density <= f.lrho;
    in_left_u <= f.lu;
    in_left_v <= f.lv;
    in_left_pressure <= f.lp;
    in_right_density <= f.rrho;
    in_right_u <= f.ru;
    in_right_v <= f.rv;
    in_right_pressure <= f.rp;
    in_var_difference <= f.diff;
    in_component <= f.comp;
  endtask

  task automatic gap_cycles();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ?
        $urandom_range(1, 3) : $urandom_range(10, 40));
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // called just after a falling edge; returns just after the accepting edge
  task automatic send(face_t f, bit with_gap);
    if (with_gap) gap_cycles();
    @(negedge clk);
    drive_face(f);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note(f);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_gamma(bit [17:0] g);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(REG_GAMMA_IDX) << 2;
    pwdata <= {14'($urandom_range(0, 16383)), g};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[17:0] !== g) report($sformatf(" gamma readback %0d exp %0d", prdata, g));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    board.gamma = g;
    writes++;
  endtask

  function automatic logic signed [31:0] sval(int mode, int bits);
    logic signed [31:0] m;
    if (mode == 0) return $urandom;
    m = $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic face_t random_face();
    face_t f;
    int    mode;
    mode = $urandom_range(0, 3) == 0 ? 0 : 1;
    f.fx = sval(mode, 20);
    f.fy = sval(mode, 20);
    f.lu = sval(mode, 19);
    f.lv = sval(mode, 19);
    f.ru = sval(mode, 19);
    f.rv = sval(mode, 19);
    f.diff = sval(mode, 21);
    if (mode == 0) begin
      f.lrho = 31'($urandom);
      f.rrho = 31'($urandom);
      f.lp = 31'($urandom);
      f.rp = 31'($urandom);
    end else begin
      f.lrho = 31'($urandom_range(1 << 12, 1 << 21));
      f.rrho = 31'($urandom_range(1 << 12, 1 << 21));
      f.lp = 31'($urandom_range(1 << 12, 1 << 23));
      f.rp = 31'($urandom_range(1 << 12, 1 << 23));
    end
    if ($urandom_range(0, 40) == 0) begin
      f.fx = '0;
      f.fy = '0;
    end
    if ($urandom_range(0, 40) == 0) f.lrho = '0;
    if ($urandom_range(0, 40) == 0) f.rp = '0;
    f.comp = 2'($urandom_range(0, 3));
    return f;
  endfunction

  function automatic face_t plain_face(logic signed [31:0] fx, logic signed [31:0] fy,
                                       logic signed [31:0] diff, logic [1:0] comp);
    face_t f;
    f.fx = fx;
    f.fy = fy;
    f.lu = 32'sd65536;
    f.lv = -32'sd32768;
    f.ru = 32'sd20000;
    f.rv = 32'sd9000;
    f.lrho = 31'd65536;
    f.rrho = 31'd80000;
    f.lp = 31'd65536;
    f.rp = 31'd70000;
    f.diff = diff;
    f.comp = comp;
    return f;
  endfunction

  initial begin
    face_t       f;
    bit   [17:0] settings[5];
    board = new();
    board.gamma = GAMMA_RESET;
    rst_n = 1'b0;
    start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    drive_face(plain_face(32'sd0, 32'sd0, 32'sd0, 2'd0));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int c = 0; c < 4; c++) send(plain_face(32'sd65536, 32'sd0, 32'sd131072, 2'(c)), 0);
    send(plain_face(0, 0, 32'sh7FFF_FFFF, 0), 0);
    send(plain_face(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1), 0);
    send(plain_face(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 2), 0);
    send(plain_face(32'sd1, -32'sd1, -32'sd1, 3), 0);
    f = plain_face(32'sd65536, 32'sd65536, -32'sd65536, 0);
    f.lrho = '0;
    f.rrho = '0;
    send(f, 0);
    f.lp = '0;
    f.rp = '0;
    f.lrho = 31'h7FFF_FFFF;
    send(f, 0);
    f = plain_face(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    f.lu = 32'sh8000_0000;
    f.lv = 32'sh8000_0000;
    f.ru = 32'sh7FFF_FFFF;
    f.rv = 32'sh7FFF_FFFF;
    f.lp = 31'h7FFF_FFFF;
    f.rp = 31'h7FFF_FFFF;
    f.lrho = 31'd1;
    f.rrho = 31'd1;
    send(f, 0);
    f.diff = 32'sh7FFF_FFFF;
    send(f, 0);
    f.diff = '0;
    send(f, 0);
    for (int i = 0; i < 6; i++) send(random_face(), 0);
    drain();

    settings[0] = 18'd0;
    settings[1] = 18'd65536;
    settings[2] = 18'd196608;
    settings[3] = 18'h3FFFF;
    settings[4] = 18'($urandom_range(65536, 196608));
    for (int ph = 0; ph <= 5; ph++) begin
      write_gamma(ph == 5 ? GAMMA_RESET : settings[ph]);
      for (int i = 0; i < 250; i++) begin
        send(random_face(), $urandom_range(0, 4) != 0 || i < 30);
        if (ph == 2 && i == 120) drain();
      end
      drain();
    end

    $display("%0d face transactions, %0d results checked, %0d gamma writes",
             sent, board.checked, writes);
    $display("covered zero faces, zero density and pressure, saturation, all components");
    if (errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, board.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
